>>> hw/rtl/stt_pkg.sv
// shared types and constants for the transposition table core
// entry layout, interface widths, operation and bound codes, controller interface
// no dependencies
`default_nettype none

package stt_pkg;

    localparam int OP_W        = 2;
    localparam int S_TDATA_W   = 168;
    localparam int M_TDATA_W   = 48;
    localparam int M_TUSER_W   = 2;
    localparam int CFG_W       = 15;
    localparam int SCORE_EXT_W = 18;

    localparam logic [OP_W-1:0] OP_PROBE = 2'd0;
    localparam logic [OP_W-1:0] OP_STORE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] BOUND_EXACT = 2'd0;
    localparam logic [1:0] BOUND_UPPER = 2'd1;
    localparam logic [1:0] BOUND_LOWER = 2'd2;

    localparam int MATE_NEAR  = 1000;
    localparam int MATE_RESET = 30000;

    typedef struct packed {
        logic [31:0]        move;
        logic [1:0]         kind;
        logic signed [15:0] score;
        logic [7:0]         depth;
        logic [63:0]        key;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic capture;
        logic read;
        logic adjust;
        logic load_out;
        logic store_wr;
        logic sweep_wr;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            out_free;
        logic            sweep_last;
    } status_t;

endpackage

`default_nettype wire

>>> hw/rtl/stt_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none

module stt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/stt_ctrl.sv
// controller state machine of the transposition table core
// depends on stt_pkg for command and status types and operation codes
`default_nettype none

module stt_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire stt_pkg::status_t status,
    output stt_pkg::cmd_t         cmd
);

    typedef enum logic [4:0] {
        ST_CLEAR   = 5'b00001,
        ST_IDLE    = 5'b00010,
        ST_READ    = 5'b00100,
        ST_ADJUST  = 5'b01000,
        ST_RESOLVE = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.sweep_wr = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                // operation is held in the datapath from here on
                unique case (status.op)
                    stt_pkg::OP_PROBE:
                    begin
                        cmd.read   = 1'b1;
                        state_next = ST_ADJUST;
                    end
                    stt_pkg::OP_STORE:
                    begin
                        cmd.adjust = 1'b1;
                        state_next = ST_RESOLVE;
                    end
                    default:
                    begin
                        state_next = ST_RESOLVE;
                    end
                endcase
            end
            ST_ADJUST:
            begin
                cmd.adjust = 1'b1;
                state_next = ST_RESOLVE;
            end
            ST_RESOLVE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.store_wr = (status.op == stt_pkg::OP_STORE);
                    state_next   = (status.op == stt_pkg::OP_CLEAR) ? ST_CLEAR : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/stt_datapath.sv
// datapath of the transposition table core: input and config registers,
// score adjust, bound test, output register, sweep counter and entry ram
// depends on stt_pkg and stt_ram
`default_nettype none

module stt_datapath #(
    parameter int TABLE_ENTRIES = 65536
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire stt_pkg::cmd_t                   cmd,
    output stt_pkg::status_t                     status,
    input  wire logic [stt_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic [stt_pkg::OP_W-1:0]        s_tuser,
    input  wire logic                            cfg_valid,
    input  wire logic [stt_pkg::CFG_W-1:0]       cfg_data,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [stt_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic      [stt_pkg::M_TUSER_W-1:0]   m_tuser
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int SW    = stt_pkg::SCORE_EXT_W;
    localparam logic signed [SW-1:0] TH_HI_RESET =
        SW'(stt_pkg::MATE_RESET - stt_pkg::MATE_NEAR);
    localparam logic signed [SW-1:0] TH_LO_RESET =
        SW'(stt_pkg::MATE_NEAR - stt_pkg::MATE_RESET);
    localparam logic signed [SW-1:0] NEAR = SW'(stt_pkg::MATE_NEAR);
    localparam logic signed [SW-1:0] S16_MAX = SW'(32767);
    localparam logic signed [SW-1:0] S16_MIN = -SW'(32768);

    function automatic logic signed [15:0] sat16(input logic signed [SW-1:0] v);
        logic signed [15:0] r;
        priority if (v > S16_MAX)
        begin
            r = 16'sh7fff;
        end
        else if (v < S16_MIN)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    // captured item
    logic [stt_pkg::OP_W-1:0] op_reg;
    logic [63:0]              key_reg;
    logic [7:0]               depth_reg;
    logic signed [15:0]       alpha_reg;
    logic signed [15:0]       beta_reg;
    logic signed [15:0]       score_in_reg;
    logic [1:0]               kind_reg;
    logic [31:0]              move_reg;
    logic [7:0]               ply_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            key_reg      <= s_tdata[63:0];
            depth_reg    <= s_tdata[71:64];
            alpha_reg    <= s_tdata[87:72];
            beta_reg     <= s_tdata[103:88];
            score_in_reg <= s_tdata[119:104];
            kind_reg     <= s_tdata[121:120];
            move_reg     <= s_tdata[153:122];
            ply_reg      <= s_tdata[161:154];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg <= stt_pkg::OP_PROBE;
        end
        else if (cmd.capture)
        begin
            op_reg <= s_tuser;
        end
    end

    // mate thresholds, kept precomputed
    logic signed [SW-1:0] th_hi_reg;
    logic signed [SW-1:0] th_lo_reg;
    logic signed [SW-1:0] mate_ext;

    assign mate_ext = {{(SW-stt_pkg::CFG_W){1'b0}}, cfg_data};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            th_hi_reg <= TH_HI_RESET;
            th_lo_reg <= TH_LO_RESET;
        end
        else if (cfg_valid)
        begin
            th_hi_reg <= mate_ext - NEAR;
            th_lo_reg <= NEAR - mate_ext;
        end
    end

    // entry ram
    logic [IDX_W-1:0]           idx;
    logic [IDX_W-1:0]           sweep_cnt_reg;
    logic                       wr_en;
    logic [IDX_W-1:0]           wr_addr;
    stt_pkg::entry_t            wr_entry;
    logic [stt_pkg::ENTRY_W-1:0] rd_data;
    stt_pkg::entry_t            rd_entry;
    logic signed [SW-1:0]       adj_reg;

    assign idx      = key_reg[IDX_W-1:0];
    assign rd_entry = stt_pkg::entry_t'(rd_data);
    assign wr_en    = cmd.store_wr | cmd.sweep_wr;
    assign wr_addr  = cmd.sweep_wr ? sweep_cnt_reg : idx;

    always_comb
    begin
        wr_entry = '0;
        if (!cmd.sweep_wr)
        begin
            wr_entry.key   = key_reg;
            wr_entry.depth = depth_reg;
            wr_entry.score = sat16(adj_reg);
            wr_entry.kind  = kind_reg;
            wr_entry.move  = move_reg;
        end
    end

    stt_ram #(
        .WIDTH (stt_pkg::ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (cmd.read),
        .rd_addr (idx),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_cnt_reg <= '0;
        end
        else if (cmd.sweep_wr)
        begin
            sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
        end
    end

    // mate adjust: toward node on store, back toward root on probe
    logic signed [SW-1:0] base_s;
    logic signed [SW-1:0] delta;
    logic signed [SW-1:0] step1;
    logic signed [SW-1:0] step2;
    logic signed [SW-1:0] ply_ext;
    logic                 is_store;

    assign is_store = (op_reg == stt_pkg::OP_STORE);
    assign ply_ext  = {{(SW-8){1'b0}}, ply_reg};

    always_comb
    begin
        base_s = is_store ? {{(SW-16){score_in_reg[15]}}, score_in_reg}
                          : {{(SW-16){rd_entry.score[15]}}, rd_entry.score};
        delta  = is_store ? ply_ext : -ply_ext;
        step1  = (base_s > th_hi_reg) ? base_s + delta : base_s;
        step2  = (step1 < th_lo_reg) ? step1 - delta : step1;
    end

    logic hit_reg;
    logic depth_ok_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.adjust)
        begin
            adj_reg      <= step2;
            hit_reg      <= (rd_entry.key == key_reg);
            depth_ok_reg <= (rd_entry.depth >= depth_reg);
        end
    end

    // bound test
    logic signed [SW-1:0] alpha_ext;
    logic signed [SW-1:0] beta_ext;
    logic                 probe_hit;
    logic                 usable_c;
    logic signed [15:0]   score_c;

    assign alpha_ext = {{(SW-16){alpha_reg[15]}}, alpha_reg};
    assign beta_ext  = {{(SW-16){beta_reg[15]}}, beta_reg};
    assign probe_hit = (op_reg == stt_pkg::OP_PROBE) && hit_reg;

    always_comb
    begin
        usable_c = 1'b0;
        score_c  = '0;
        if (probe_hit && depth_ok_reg)
        begin
            unique case (rd_entry.kind)
                stt_pkg::BOUND_EXACT:
                begin
                    usable_c = 1'b1;
                    score_c  = sat16(adj_reg);
                end
                stt_pkg::BOUND_UPPER:
                begin
                    if (adj_reg <= alpha_ext)
                    begin
                        usable_c = 1'b1;
                        score_c  = alpha_reg;
                    end
                end
                stt_pkg::BOUND_LOWER:
                begin
                    if (adj_reg >= beta_ext)
                    begin
                        usable_c = 1'b1;
                        score_c  = beta_reg;
                    end
                end
                default:
                begin
                    usable_c = 1'b0;
                end
            endcase
        end
    end

    // output register
    logic               out_valid_reg;
    logic               out_hit_reg;
    logic               out_usable_reg;
    logic [31:0]        out_move_reg;
    logic signed [15:0] out_score_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_hit_reg    <= probe_hit;
            out_usable_reg <= usable_c;
            out_move_reg   <= probe_hit ? rd_entry.move : 32'd0;
            out_score_reg  <= score_c;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_score_reg, out_move_reg};
    assign m_tuser  = {out_usable_reg, out_hit_reg};

    assign status.op         = op_reg;
    assign status.out_free   = !out_valid_reg || m_tready;
    assign status.sweep_last = &sweep_cnt_reg;

endmodule

`default_nettype wire

>>> hw/rtl/search_transposition_table_core.sv
// Direct-mapped, always-replace transposition table. A probe steps through accept,
// ram read, mate adjust with tag and depth compare, and bound test; a store through
// accept, mate adjust and ram write; a clear or an unused operation through accept,
// decode and result. After a clear's result the table is swept before the next item
// is taken. A result waiting on m_tready holds the block in its result state; apart
// from a clear, the next item can be accepted once the result is in the output
// register. The step sequence is set by the entry ram with its registered read and
// the one shared adjust unit. After reset the table is swept to zero with s_tready
// low; configuration writes are taken at any time.
// top level: depends on stt_pkg, stt_ctrl, stt_datapath and stt_ram
`default_nettype none

module search_transposition_table_core #(
    parameter int TABLE_ENTRIES = 65536
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // position_key, search_depth, window_low, window_high, new_score,
    // bound_kind, new_move, ply_from_root, zero pad
    input  wire logic [stt_pkg::S_TDATA_W-1:0]   s_tdata,
    // operation
    input  wire logic [stt_pkg::OP_W-1:0]        s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // found_move, found_score
    output logic      [stt_pkg::M_TDATA_W-1:0]   m_tdata,
    // key_hit, score_usable
    output logic      [stt_pkg::M_TUSER_W-1:0]   m_tuser,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    // mate_score
    input  wire logic [stt_pkg::CFG_W-1:0]       cfg_data
);

    stt_pkg::cmd_t    cmd;
    stt_pkg::status_t status;
    logic             s_tready_ctrl;

    assign cfg_ready = 1'b1;
    assign s_tready  = s_tready_ctrl;

    stt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready_ctrl),
        .status   (status),
        .cmd      (cmd)
    );

    stt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

>>> tb/sv/search_transposition_table_core_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for search_transposition_table_core: directed table, then random
// phases over several mate settings; depends on stt_pkg and the core rtl only
module search_transposition_table_core_tb;

    localparam int S_TDATA_W = stt_pkg::S_TDATA_W;
    localparam int OP_W      = stt_pkg::OP_W;
    localparam int M_TDATA_W = stt_pkg::M_TDATA_W;
    localparam int M_TUSER_W = stt_pkg::M_TUSER_W;
    localparam int CFG_W     = stt_pkg::CFG_W;

    localparam int TABLE_N = 65536;
    localparam logic [1:0] OP_NONE        = 2'd3;
    localparam logic [1:0] BOUND_RESERVED = 2'd3;
    localparam int PHASES     = 6;
    localparam int PHASE_LEN  = 275;
    localparam int HOLD_LEN   = 400;
    localparam int DRAIN_WAIT = 8;

    typedef struct {
        logic [1:0]         op;
        logic [63:0]        key;
        logic [7:0]         depth;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
        logic signed [15:0] score;
        logic [1:0]         kind;
        logic [31:0]        move;
        logic [7:0]         ply;
    } tt_item_t;

    typedef struct {
        logic               hit;
        logic [31:0]        move;
        logic               usable;
        logic signed [15:0] score;
    } tt_result_t;

    typedef struct {
        tt_item_t   item;
        bit         fixed;
        tt_result_t want;
    } tt_row_t;

    logic clk;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [OP_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_W-1:0] cfg_data = '0;

    logic [63:0]        tag_mem   [TABLE_N];
    logic [7:0]         depth_mem [TABLE_N];
    logic signed [15:0] score_mem [TABLE_N];
    logic [1:0]         kind_mem  [TABLE_N];
    logic [31:0]        move_mem  [TABLE_N];
    logic [CFG_W-1:0]   mate_cfg = CFG_W'(stt_pkg::MATE_RESET);

    tt_result_t  pending_results[$];
    tt_row_t     directed_rows[$];
    logic [63:0] key_pool[32];
    int mismatch_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int clears_left = 3;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    search_transposition_table_core #(
        .TABLE_ENTRIES(TABLE_N)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(20_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic tt_item_t mk(logic [1:0] op, logic [63:0] key, int depth, int alpha,
                                    int beta, int score, logic [1:0] kind, logic [31:0] move,
                                    int ply);
        tt_item_t it;
        it.op    = op;
        it.key   = key;
        it.depth = depth[7:0];
        it.alpha = alpha[15:0];
        it.beta  = beta[15:0];
        it.score = score[15:0];
        it.kind  = kind;
        it.move  = move;
        it.ply   = ply[7:0];
        return it;
    endfunction

    function automatic tt_result_t rs(logic hit, logic [31:0] move, logic usable, int score);
        tt_result_t r;
        r.hit    = hit;
        r.move   = move;
        r.usable = usable;
        r.score  = score[15:0];
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(int v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return 16'(v);
    endfunction

    function automatic void wipe_entries();
        foreach (tag_mem[i])
        begin
            tag_mem[i]   = '0;
            depth_mem[i] = '0;
            score_mem[i] = '0;
            kind_mem[i]  = '0;
            move_mem[i]  = '0;
        end
    endfunction

    // table lookup / replace as the core should do it, one item at a time
    function automatic tt_result_t predict_entry(tt_item_t it);
        tt_result_t r;
        int idx;
        int mate;
        int s;
        int ply;
        r = rs(1'b0, '0, 1'b0, 0);
        idx = int'(it.key[15:0]);
        mate = int'(mate_cfg);
        ply = int'(it.ply);
        case (it.op)
            stt_pkg::OP_PROBE:
            begin
                if (tag_mem[idx] == it.key)
                begin
                    r.hit = 1'b1;
                    r.move = move_mem[idx];
                    if (depth_mem[idx] >= it.depth)
                    begin
                        s = int'(score_mem[idx]);
                        if (s > mate - stt_pkg::MATE_NEAR)
                            s = s - ply;
                        if (s < -mate + stt_pkg::MATE_NEAR)
                            s = s + ply;
                        if (kind_mem[idx] == stt_pkg::BOUND_EXACT)
                        begin
                            r.usable = 1'b1;
                            r.score = sat16(s);
                        end
                        else if (kind_mem[idx] == stt_pkg::BOUND_UPPER &&
                                 s <= int'(it.alpha))
                        begin
                            r.usable = 1'b1;
                            r.score = it.alpha;
                        end
                        else if (kind_mem[idx] == stt_pkg::BOUND_LOWER &&
                                 s >= int'(it.beta))
                        begin
                            r.usable = 1'b1;
                            r.score = it.beta;
                        end
                    end
                end
            end
            stt_pkg::OP_STORE:
            begin
                s = int'(it.score);
                if (s > mate - stt_pkg::MATE_NEAR)
                    s = s + ply;
                if (s < -mate + stt_pkg::MATE_NEAR)
                    s = s - ply;
                tag_mem[idx]   = it.key;
                depth_mem[idx] = it.depth;
                score_mem[idx] = sat16(s);
                kind_mem[idx]  = it.kind;
                move_mem[idx]  = it.move;
            end
            stt_pkg::OP_CLEAR:
                wipe_entries();
            default:
                ;
        endcase
        return r;
    endfunction

    function automatic logic signed [15:0] pick_score();
        int v;
        case ($urandom_range(0, 5))
            0: v = int'($urandom);
            1: v = int'(mate_cfg) - stt_pkg::MATE_NEAR + int'($urandom_range(0, 40)) - 20;
            2: v = -int'(mate_cfg) + stt_pkg::MATE_NEAR + int'($urandom_range(0, 40)) - 20;
            3: v = $urandom_range(0, 1) ? 32767 : -32768;
            4: v = int'($urandom_range(0, 400)) - 200;
            default: v = ($urandom_range(0, 1) ? 1 : -1)
                         * (int'(mate_cfg) - int'($urandom_range(0, 300)));
        endcase
        return 16'(v);
    endfunction

    function automatic void refill_keys();
        logic [63:0] k;
        for (int i = 0; i < 32; i++)
        begin
            k = {$urandom, $urandom};
            if (i % 3 == 2)
                k[15:0] = key_pool[i-1][15:0];
            key_pool[i] = k;
        end
        key_pool[0] = '0;
        key_pool[1] = '1;
    endfunction

    function automatic tt_item_t rand_item();
        tt_item_t it;
        int pick;
        pick = $urandom_range(0, 99);
        if (clears_left > 0 && $urandom_range(0, 299) == 0)
        begin
            it.op = stt_pkg::OP_CLEAR;
            clears_left--;
        end
        else if (pick < 55)
            it.op = stt_pkg::OP_PROBE;
        else if (pick < 97)
            it.op = stt_pkg::OP_STORE;
        else
            it.op = OP_NONE;
        it.key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                             : key_pool[$urandom_range(0, 31)];
        case ($urandom_range(0, 9))
            0: it.depth = 8'd0;
            1: it.depth = 8'hff;
            2, 3, 4, 5: it.depth = 8'($urandom_range(0, 7));
            default: it.depth = 8'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 7))
            0: it.ply = 8'd0;
            1: it.ply = 8'hff;
            default: it.ply = 8'($urandom_range(0, 255));
        endcase
        it.alpha = pick_score();
        it.beta  = pick_score();
        it.score = pick_score();
        it.kind  = ($urandom_range(0, 19) == 0) ? BOUND_RESERVED : 2'($urandom_range(0, 2));
        it.move  = $urandom;
        return it;
    endfunction

    task automatic log_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        $display("ERROR %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    task automatic check_result();
        tt_result_t want;
        if (pending_results.size() == 0)
        begin
            log_mismatch("result with nothing pending", 64'({m_tuser, m_tdata}), '0);
            return;
        end
        want = pending_results.pop_front();
        if (m_tuser[0] !== want.hit)
            log_mismatch("key_hit", 64'(m_tuser[0]), 64'(want.hit));
        if (m_tdata[31:0] !== want.move)
            log_mismatch("found_move", 64'(m_tdata[31:0]), 64'(want.move));
        if (m_tuser[1] !== want.usable)
            log_mismatch("score_usable", 64'(m_tuser[1]), 64'(want.usable));
        if (m_tdata[47:32] !== want.score)
            log_mismatch("found_score", 64'(m_tdata[47:32]), 64'(want.score));
    endtask

    // result side: check accepted items, then pick the next tready
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_result();
        if (hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic send_item(tt_item_t it, bit fixed, tt_result_t want);
        tt_result_t got;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {6'd0, it.ply, it.move, it.kind, it.score, it.beta, it.alpha, it.depth,
                     it.key};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        got = predict_entry(it);
        pending_results.push_back(fixed ? want : got);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_mate(logic [CFG_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        mate_cfg = v;
    endtask

    initial
    begin
        logic [63:0] ka;
        logic [63:0] kb;
        logic [63:0] kc;
        logic [63:0] kd;
        logic [63:0] ke;
        tt_result_t none;
        logic [CFG_W-1:0] mate_val;
        ka = 64'h1234_5678_9abc_0010;
        kb = 64'h8000_0000_0000_0020;
        kc = 64'h0f0f_f0f0_5a5a_0030;
        kd = 64'hdead_beef_0000_0040;
        ke = 64'hcafe_f00d_0000_0050;
        none = rs(1'b0, '0, 1'b0, 0);
        wipe_entries();

        // op, key, depth, alpha, beta, score, kind, move, ply
        directed_rows.push_back('{mk(stt_pkg::OP_PROBE, '0, 0, 0, 0, 0,
                                     stt_pkg::BOUND_EXACT, '0, 0),
                                  1'b1, rs(1'b1, '0, 1'b1, 0)});
        directed_rows.push_back('{mk(stt_pkg::OP_PROBE, '0, 1, 0, 0, 0,
                                     stt_pkg::BOUND_EXACT, '0, 0),
                                  1'b1, rs(1'b1, '0, 1'b0, 0)});
        directed_rows.push_back('{mk(stt_pkg::OP_PROBE, 64'h5, 0, 0, 0, 0,
                                     stt_pkg::BOUND_EXACT, '0, 0),
                                  1'b1, none});
        directed_rows.push_back('{mk(stt_pkg::OP_STORE, '1, 255, 0, 0, 100,
                                     stt_pkg::BOUND_EXACT, '1, 0),
                                  1'b1, none});
        directed_rows.push_back('{mk(stt_pkg::OP_PROBE, '1, 255, -32768, 32767, 0,
                                     stt_pkg::BOUND_EXACT, '0, 255),
                                  1'b1, rs(1'b1, '1, 1'b1, 100)});
        directed_rows.push_back('{mk(stt_pkg::OP_PROBE, 64'hffff, 0, 0, 0, 0,
                                     stt_pkg::BOUND_EXACT, '0, 0),
                                  1'b1, none});
        directed_rows.push_back('{mk(stt_pkg::OP_STORE, ka, 4, 0, 0, 29500,
                                     stt_pkg::BOUND_EXACT, 32'h1111, 10),
                                  1'b1, none});
        directed_rows.push_back('{mk(stt_pkg::OP_PROBE, ka, 4, 0, 0, 0,
                                     stt_pkg::BOUND_EXACT, '0, 3),
                                  1'b0, none});
        directed_rows.push_back('{mk(stt_pkg::OP_STORE, kb, 8, 0, 0, -29800,
                                     stt_pkg::BOUND_LOWER, 32'h2222, 255),
                                  1'b1, none});
        directed_rows.push_back('{mk(stt_pkg::OP_PROBE, kb, 2, 0, -31000, 0,
                                     stt_pkg::BOUND_EXACT, '0, 0),
                                  1'b0, none});
        directed_rows.push_back('{mk(stt_pkg::OP_PROBE, kb, 2, 0, 0, 0,
                                     stt_pkg::BOUND_EXACT, '0, 0),
                                  1'b0, none});
        directed_rows.push_back('{mk(stt_pkg::OP_STORE, kc, 10, 0, 0, 32767,
                                     stt_pkg::BOUND_UPPER, 32'h3333, 255),
                                  1'b1, none});
        directed_rows.push_back('{mk(stt_pkg::OP_PROBE, kc, 10, 32767, 0, 0,
                                     stt_pkg::BOUND_EXACT, '0, 0),
                                  1'b0, none});
        directed_rows.push_back('{mk(stt_pkg::OP_PROBE, kc, 11, 32767, 0, 0,
                                     stt_pkg::BOUND_EXACT, '0, 0),
                                  1'b0, none});
        directed_rows.push_back('{mk(stt_pkg::OP_STORE, kd, 0, 0, 0, 0,
                                     BOUND_RESERVED, 32'h4444, 0),
                                  1'b1, none});
        directed_rows.push_back('{mk(stt_pkg::OP_PROBE, kd, 0, 32767, -32768, 0,
                                     stt_pkg::BOUND_EXACT, '0, 0),
                                  1'b0, none});
        directed_rows.push_back('{mk(stt_pkg::OP_STORE, ke, 255, 0, 0, -32768,
                                     stt_pkg::BOUND_EXACT, 32'h8000_0001, 255),
                                  1'b1, none});
        directed_rows.push_back('{mk(stt_pkg::OP_PROBE, ke, 255, 0, 0, 0,
                                     stt_pkg::BOUND_EXACT, '0, 255),
                                  1'b0, none});
        directed_rows.push_back('{mk(OP_NONE, '1, 255, -1, -1, -1,
                                     BOUND_RESERVED, '1, 255),
                                  1'b1, none});
        directed_rows.push_back('{mk(stt_pkg::OP_PROBE, ka, 0, -32768, 32767, 0,
                                     stt_pkg::BOUND_EXACT, '0, 255),
                                  1'b0, none});
        directed_rows.push_back('{mk(stt_pkg::OP_CLEAR, '0, 0, 0, 0, 0,
                                     stt_pkg::BOUND_EXACT, '0, 0),
                                  1'b1, none});
        directed_rows.push_back('{mk(stt_pkg::OP_PROBE, ka, 0, 0, 0, 0,
                                     stt_pkg::BOUND_EXACT, '0, 0),
                                  1'b1, none});
        directed_rows.push_back('{mk(stt_pkg::OP_PROBE, '0, 0, 0, 0, 0,
                                     stt_pkg::BOUND_EXACT, '0, 0),
                                  1'b1, rs(1'b1, '0, 1'b1, 0)});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        write_mate(CFG_W'(stt_pkg::MATE_RESET));

        send_idle_pct = 33;
        recv_idle_pct = 64;
        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].want);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            case (ph)
                0: mate_val = '0;
                1: mate_val = '1;
                2: mate_val = CFG_W'(stt_pkg::MATE_NEAR);
                3: mate_val = CFG_W'(stt_pkg::MATE_RESET);
                default: mate_val = CFG_W'($urandom_range(0, 32767));
            endcase
            write_mate(mate_val);
            send_idle_pct = (ph < 2) ? 33 : (ph < 4) ? 64 : 0;
            recv_idle_pct = (ph < 2) ? 64 : (ph < 4) ? 33 : 0;
            refill_keys();
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                // long output stall while items keep coming
                if (ph == 1 && n == 40)
                    hold_req = 1'b1;
                send_item(rand_item(), 1'b0, none);
            end
        end
        drain();

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> search_transposition_table_core.f
hw/rtl/stt_pkg.sv
hw/rtl/stt_ram.sv
hw/rtl/stt_ctrl.sv
hw/rtl/stt_datapath.sv
hw/rtl/search_transposition_table_core.sv
tb/sv/search_transposition_table_core_tb.sv
